[hdl/vqrc_pkg.sv]
// Shared constants for the video QP rate controller.
package vqrc_pkg;

   // Field widths
   localparam int QP_W      = 6;
   localparam int RATE_W    = 16;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_QP      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_QP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BITRATE = 2'd2;

   // Reset values of the configuration registers and the quantizer
   localparam logic [QP_W-1:0]   MIN_QP_RST      = 6'd28;
   localparam logic [QP_W-1:0]   MAX_QP_RST      = 6'd36;
   localparam logic [RATE_W-1:0] MAX_BITRATE_RST = 16'd439;

   // Target is max_bitrate * 875 / 1000, which is exactly max_bitrate * 7 / 8
   localparam int TGT_PROD_W = 19;
   localparam logic [TGT_PROD_W-1:0] TGT_MUL = 19'd7;
   localparam int TGT_SHIFT = 3;

   // Offset is min(target / 10, 128); target / 10 exceeds 128 from this value on
   localparam logic [RATE_W-1:0] OFS_SAT_FROM = 16'd1290;
   localparam logic [7:0]        OFS_CAP      = 8'd128;
   localparam int OFS_IN_W   = 11;
   localparam int OFS_PROD_W = 27;
   localparam logic [OFS_PROD_W-1:0] RECIP10 = 27'd52429;
   localparam int RECIP10_SHIFT = 19;

   // Under-target threshold: rate * 100 < target * 75
   localparam int LIM_W = 23;
   localparam logic [LIM_W-1:0] PCT_FULL  = 23'd100;
   localparam logic [LIM_W-1:0] PCT_UNDER = 23'd75;

   // Hold-off intervals in milliseconds
   localparam logic [TIME_W-1:0] DEC_INTERVAL = 32'd500;
   localparam logic [TIME_W-1:0] OVF_HOLDOFF  = 32'd2000;

   // Cycles for the derived thresholds to settle after a register change
   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

endpackage

[hdl/video_qp_rate_controller.sv]
// Top level of the video QP rate controller: one QP decision per frame request.
//
// Each request (timestamp in ms, measured bitrate in kbps) yields one response with
// the quantizer for the frame and an encode/skip flag. A request enters an input
// register and its decision is formed by a single pass of compare and clamp logic
// into the response register once that register is free, so one request is taken per
// cycle while the response side keeps up. A configuration write to a known index
// recentres the quantizer, and any write retimes the registered target thresholds,
// which keeps req_ready low while they settle after the write and after reset.
module video_qp_rate_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [vqrc_pkg::TIME_W-1:0]    req_timestamp_ms,
   input  logic [vqrc_pkg::RATE_W-1:0]    req_measured_bitrate,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [vqrc_pkg::QP_W-1:0]      rsp_quantizer,
   output logic                           rsp_encode_frame,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [vqrc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vqrc_pkg::CSR_DAT_W-1:0] csr_data
);
   import vqrc_pkg::*;

   // Configuration and derived thresholds
   logic [QP_W-1:0]   min_qp_ff, min_qp_in;
   logic [QP_W-1:0]   max_qp_ff, max_qp_in;
   logic [RATE_W-1:0] max_bitrate_ff, max_bitrate_in;
   logic [RATE_W-1:0] target_ff, target_in;
   logic [7:0]        offset_ff, offset_in;
   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [1:0]        settle_ff, settle_in;
   logic              csr_we;
   logic              csr_hit;
   logic [QP_W:0]     recentre_sum;

   // Controller state
   logic [QP_W-1:0]   qp_ff, qp_in;
   logic [TIME_W-1:0] last_ovf_ff, last_ovf_in;
   logic [TIME_W-1:0] last_dec_ff, last_dec_in;

   // Input stage
   logic              in_valid_ff, in_valid_in;
   logic [TIME_W-1:0] in_ts_ff;
   logic [RATE_W-1:0] in_rate_ff;

   // Result stage
   logic              rsp_valid_ff, rsp_valid_in;
   logic [QP_W-1:0]   rsp_qp_ff;
   logic              rsp_enc_ff;

   // Decision logic
   logic              advance, fire, req_fire;
   logic              over, under, dec_ok;
   logic [LIM_W-1:0]  rate_pct;
   logic [RATE_W:0]   rate_plus_ofs;
   logic [TIME_W-1:0] since_dec, since_ovf;
   logic [QP_W:0]     qp_plus;
   logic [QP_W-1:0]   qp_inc, qp_mid, qp_under, qp_next;
   logic              enc_next;
   logic [OFS_PROD_W-1:0] ofs_prod;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = (settle_ff == 2'd0) && (!in_valid_ff || advance);
   assign req_fire  = req_valid && req_ready;

   // Derive thresholds from the registers: target first, then offset and limit from the registered target
   always_comb begin
      target_in = RATE_W'((TGT_PROD_W'(max_bitrate_ff) * TGT_MUL) >> TGT_SHIFT);
      ofs_prod  = (OFS_PROD_W'(target_ff[OFS_IN_W-1:0]) * RECIP10) >> RECIP10_SHIFT;
      offset_in = (target_ff >= OFS_SAT_FROM) ? OFS_CAP : ofs_prod[7:0];
      limit_in  = LIM_W'(target_ff) * PCT_UNDER;
   end

   // Decode configuration writes; any known index recentres the quantizer
   always_comb begin
      min_qp_in      = min_qp_ff;
      max_qp_in      = max_qp_ff;
      max_bitrate_in = max_bitrate_ff;
      csr_hit        = 1'b1;
      unique case (csr_index)
         CSR_MIN_QP:      min_qp_in      = csr_data[QP_W-1:0];
         CSR_MAX_QP:      max_qp_in      = csr_data[QP_W-1:0];
         CSR_MAX_BITRATE: max_bitrate_in = csr_data[RATE_W-1:0];
         default:         csr_hit        = 1'b0;
      endcase
      recentre_sum = (QP_W+1)'(min_qp_in) + (QP_W+1)'(max_qp_in);
      if (csr_we) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   // Form the quantizer decision for the item in the input stage
   always_comb begin
      over          = in_rate_ff > target_ff;
      rate_pct      = LIM_W'(in_rate_ff) * PCT_FULL;
      under         = rate_pct < limit_ff;
      rate_plus_ofs = (RATE_W+1)'(in_rate_ff) + (RATE_W+1)'(offset_ff);
      since_dec     = in_ts_ff - last_dec_ff;
      since_ovf     = in_ts_ff - last_ovf_ff;
      dec_ok        = (rate_plus_ofs < (RATE_W+1)'(target_ff)) &&
                      (since_dec >= DEC_INTERVAL) && (since_ovf >= OVF_HOLDOFF);

      qp_plus  = (QP_W+1)'(qp_ff) + (QP_W+1)'(1);
      qp_inc   = (qp_plus > (QP_W+1)'(max_qp_ff)) ? max_qp_ff : qp_plus[QP_W-1:0];
      if (dec_ok && qp_ff != '0) begin
         qp_mid = qp_ff - QP_W'(1);
      end else begin
         qp_mid = qp_ff;
      end
      qp_under = (qp_mid < min_qp_ff) ? min_qp_ff : qp_mid;

      qp_next     = qp_ff;
      enc_next    = 1'b1;
      last_ovf_in = last_ovf_ff;
      last_dec_in = last_dec_ff;
      if (over && qp_ff == max_qp_ff) begin
         enc_next    = 1'b0;
         last_ovf_in = in_ts_ff;
      end else if (over) begin
         qp_next     = qp_inc;
         last_ovf_in = in_ts_ff;
      end else if (under) begin
         qp_next = qp_under;
         if (dec_ok) begin
            last_dec_in = in_ts_ff;
         end
      end

      if (csr_we && csr_hit) begin
         qp_in = recentre_sum[QP_W:1];
      end else if (fire) begin
         qp_in = qp_next;
      end else begin
         qp_in = qp_ff;
      end

      in_valid_in  = req_fire || (in_valid_ff && !advance);
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_qp_ff      <= MIN_QP_RST;
         max_qp_ff      <= MAX_QP_RST;
         max_bitrate_ff <= MAX_BITRATE_RST;
         settle_ff      <= SETTLE_CYCLES;
         qp_ff          <= MIN_QP_RST;
         last_ovf_ff    <= '0;
         last_dec_ff    <= '0;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            min_qp_ff      <= min_qp_in;
            max_qp_ff      <= max_qp_in;
            max_bitrate_ff <= max_bitrate_in;
         end
         settle_ff <= settle_in;
         qp_ff     <= qp_in;
         if (fire) begin
            last_ovf_ff <= last_ovf_in;
            last_dec_ff <= last_dec_in;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: thresholds, input stage and result stage
   always_ff @(posedge clock) begin
      target_ff <= target_in;
      offset_ff <= offset_in;
      limit_ff  <= limit_in;
      if (req_fire) begin
         in_ts_ff   <= req_timestamp_ms;
         in_rate_ff <= req_measured_bitrate;
      end
      if (fire) begin
         rsp_qp_ff  <= qp_next;
         rsp_enc_ff <= enc_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_quantizer    = rsp_qp_ff;
   assign rsp_encode_frame = rsp_enc_ff;

   // A skipped frame always reports the ceiling quantizer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_encode_frame |-> rsp_quantizer == max_qp_ff)
      else $error("skip response with quantizer below max_qp");

   // No request is taken right after a configuration write
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("request accepted while thresholds settle");

   // The quantizer moves only on a decision or a configuration write
   assert property (@(posedge clock) disable iff (reset)
      !fire && !csr_we |=> $stable(qp_ff))
      else $error("quantizer changed without a transaction");

   // An input item waiting on a full result stage is kept
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input item dropped under backpressure");

endmodule

[test/testbench.sv]
// Self-checking testbench for the video QP rate controller.
`timescale 1ns / 1ps

// Tracks the controller's quantizer, timestamps and registers, and checks decisions.
class qp_decisions;
   logic [5:0]  min_qp;
   logic [5:0]  max_qp;
   logic [15:0] max_bitrate;
   logic [5:0]  qp;
   logic [31:0] last_overflow_ms;
   logic [31:0] last_decrease_ms;
   logic [5:0]  owed_qp[$];
   logic        owed_encode[$];
   int          mismatches;

   function new();
      min_qp           = vqrc_pkg::MIN_QP_RST;
      max_qp           = vqrc_pkg::MAX_QP_RST;
      max_bitrate      = vqrc_pkg::MAX_BITRATE_RST;
      qp               = vqrc_pkg::MIN_QP_RST;
      last_overflow_ms = '0;
      last_decrease_ms = '0;
      mismatches       = 0;
   endfunction

   function int unsigned target_rate();
      return (int'(max_bitrate) * 875) / 1000;
   endfunction

   function int outstanding();
      return owed_qp.size();
   endfunction

   // Store a register and recenter the quantizer; ignore unknown indexes
   function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
         vqrc_pkg::CSR_MIN_QP:      min_qp = data[5:0];
         vqrc_pkg::CSR_MAX_QP:      max_qp = data[5:0];
         vqrc_pkg::CSR_MAX_BITRATE: max_bitrate = data;
         default:                   return;
      endcase
      qp = 6'((int'(min_qp) + int'(max_qp)) / 2);
   endfunction

   // Work out the decision for one accepted frame request
   function void note_frame(logic [31:0] now, logic [15:0] rate);
      int unsigned tgt;
      int unsigned ofs;
      int unsigned rate_u;
      int unsigned next_qp;
      logic [31:0] since_dec;
      logic [31:0] since_ovf;
      logic        enc;
      tgt     = target_rate();
      ofs     = tgt / 10;
      rate_u  = rate;
      next_qp = qp;
      enc     = 1'b1;
      if (ofs > 128) ofs = 128;
      since_dec = now - last_decrease_ms;
      since_ovf = now - last_overflow_ms;
      if (rate_u > tgt && next_qp == max_qp) begin
         // already at the ceiling: skip the frame
         last_overflow_ms = now;
         enc = 1'b0;
      end else if (rate_u > tgt) begin
         last_overflow_ms = now;
         next_qp = next_qp + 1;
         if (next_qp > max_qp) next_qp = max_qp;
      end else if (rate_u * 100 < tgt * 75) begin
         if (rate_u + ofs < tgt && since_dec >= 500 && since_ovf >= 2000) begin
            last_decrease_ms = now;
            next_qp = (next_qp == 0) ? 0 : next_qp - 1;
         end
         if (next_qp < min_qp) next_qp = min_qp;
      end
      qp = 6'(next_qp);
      owed_qp.push_back(qp);
      owed_encode.push_back(enc);
   endfunction

   function void flag(string what);
      if (mismatches < 10) $display("%s", what);
      mismatches++;
   endfunction

   // Compare one response transaction with the oldest owed decision
   function void check_decision(logic [5:0] got_qp, logic got_enc);
      logic [5:0] want_qp;
      logic       want_enc;
      if (owed_qp.size() == 0) begin
         flag($sformatf("unexpected response: quantizer %0d encode %0b", got_qp, got_enc));
         return;
      end
      want_qp  = owed_qp.pop_front();
      want_enc = owed_encode.pop_front();
      if (got_qp !== want_qp)
         flag($sformatf("quantizer wrong: expected %0d, got %0d", want_qp, got_qp));
      if (got_enc !== want_enc)
         flag($sformatf("encode flag wrong: expected %0b, got %0b", want_enc, got_enc));
   endfunction
endclass

module testbench;
   localparam logic [1:0] CSR_SPARE   = 2'd3;
   localparam int SETTLE_WAIT          = 4;
   localparam int END_WAIT             = 8;
   localparam int WATCHDOG_LIMIT       = 3000;
   localparam int HOLD_AT              = 700;
   localparam int HOLD_CYCLES          = 150;
   localparam int PHASES               = 8;
   localparam int PHASE_FRAMES         = 210;

   typedef enum int {TREND_OVER, TREND_NEAR, TREND_UNDER, TREND_ANY} trend_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_timestamp_ms = '0;
   logic [15:0] req_measured_bitrate = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_quantizer;
   logic        rsp_encode_frame;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   qp_decisions tracker;
   int          sender_idle_pct = 0;
   int          stall_pct = 0;
   int          frames_accepted = 0;
   int          quiet_cycles = 0;
   int          hold_left = 0;
   bit          held_once = 1'b0;
   logic [31:0] now_ms = '0;

   video_qp_rate_controller uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_timestamp_ms     (req_timestamp_ms),
      .req_measured_bitrate (req_measured_bitrate),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_quantizer        (rsp_quantizer),
      .rsp_encode_frame     (rsp_encode_frame),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response side at random, with one long hold-off to back up the pipe
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!held_once && frames_accepted >= HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         held_once <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Observe every transaction on the three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) begin
            tracker.note_frame(req_timestamp_ms, req_measured_bitrate);
            frames_accepted++;
         end
         if (rsp_valid && rsp_ready) tracker.check_decision(rsp_quantizer, rsp_encode_frame);
      end
      if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   // Abort when nothing has moved for too long
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("video_qp_rate_controller: mismatch");
      $finish;
   end

   // Offer one frame request, with random idle cycles ahead of it
   task automatic send_frame(input logic [31:0] ts, input logic [15:0] rate);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_timestamp_ms     <= ts;
      req_measured_bitrate <= rate;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every owed response has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [5:0] lo_qp, input logic [5:0] hi_qp,
                            input logic [15:0] rate_cap);
      csr_write(vqrc_pkg::CSR_MIN_QP, 16'(lo_qp));
      csr_write(vqrc_pkg::CSR_MAX_QP, 16'(hi_qp));
      csr_write(vqrc_pkg::CSR_MAX_BITRATE, rate_cap);
   endtask

   // Choose a bitrate relative to the current target
   function automatic logic [15:0] pick_rate(trend_type trend, int unsigned tgt);
      int unsigned hi;
      case (trend)
         TREND_OVER: begin
            hi = tgt + tgt / 4 + 50;
            if (hi > 65535) hi = 65535;
            return 16'($urandom_range(hi, tgt + 1));
         end
         TREND_NEAR:  return 16'($urandom_range(tgt, (tgt * 3) / 4));
         TREND_UNDER: return 16'($urandom_range((tgt * 3) / 4, 0));
         default:     return ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(65535));
      endcase
   endfunction

   // Frame bursts that lean toward one trend, with time mostly moving forward
   task automatic run_frames(input int count);
      trend_type   trend;
      trend_type   pick;
      int          burst_left;
      int          r;
      burst_left = 0;
      trend      = TREND_ANY;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            trend      = trend_type'($urandom_range(3));
            burst_left = $urandom_range(40, 5);
         end
         burst_left--;
         pick = ($urandom_range(99) < 80) ? trend : trend_type'($urandom_range(3));
         r = $urandom_range(99);
         if (r < 75)      now_ms += $urandom_range(100, 0);
         else if (r < 93) now_ms += $urandom_range(3000, 101);
         else if (r < 97) now_ms = $urandom();
         else             now_ms -= $urandom_range(500, 1);
         send_frame(now_ms, pick_rate(pick, tracker.target_rate()));
      end
   endtask

   initial begin
      int          phase;
      logic [5:0]  lo;
      logic [5:0]  hi;
      logic [5:0]  tmp;
      logic [15:0] cap;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: hold-off at start, over target, exact target, 75 percent edge
      send_frame(32'd0, 16'd0);
      send_frame(32'd2000, 16'd0);
      send_frame(32'd2100, 16'd385);
      send_frame(32'd2133, 16'd384);
      send_frame(32'd2166, 16'd288);
      send_frame(32'd2200, 16'hFFFF);
      settle();

      // Narrow range: reach the ceiling, then skip frames
      configure(6'd30, 6'd31, 16'd439);
      send_frame(32'd2300, 16'hFFFF);
      send_frame(32'd2330, 16'hFFFF);
      send_frame(32'd2360, 16'd400);
      settle();

      // Full range: decrease spacing across the timestamp wrap, overflow hold-off
      configure(6'd0, 6'd51, 16'hFFFF);
      send_frame(32'hFFFF_FF00, 16'd0);
      send_frame(32'h0000_00F3, 16'd0);
      send_frame(32'h0000_00F4, 16'd0);
      send_frame(32'h0000_0100, 16'hFFFF);
      send_frame(32'h0000_08CF, 16'd0);
      send_frame(32'h0000_08D0, 16'd0);
      send_frame(32'h0000_1000, 16'd43007);
      send_frame(32'h0000_2000, 16'd43008);
      settle();

      // Zero target
      configure(6'd10, 6'd40, 16'd0);
      csr_write(vqrc_pkg::CSR_MAX_BITRATE, 16'd1);
      send_frame(32'h0000_3000, 16'd0);
      send_frame(32'h0000_3010, 16'd1);
      settle();

      // Inverted bounds
      configure(6'd51, 6'd0, 16'hFFFF);
      send_frame(32'h0000_4000, 16'hFFFF);
      send_frame(32'h0000_4010, 16'hFFFF);
      send_frame(32'h0000_5000, 16'd0);
      settle();

      // Write to the spare index, then decrement with the quantizer at zero
      csr_write(CSR_SPARE, 16'hA5A5);
      configure(6'd0, 6'd1, 16'd2000);
      send_frame(32'h0000_9000, 16'd0);
      settle();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: configure(6'd0, 6'd51, 16'hFFFF);
            1: configure(6'd51, 6'd51, 16'd16);
            2: configure(6'd40, 6'd12, 16'($urandom_range(65535, 16)));
            default: begin
               lo = 6'($urandom_range(51));
               hi = 6'($urandom_range(51));
               if (lo > hi && $urandom_range(99) < 80) begin
                  tmp = lo;
                  lo  = hi;
                  hi  = tmp;
               end
               cap = $urandom_range(1) ? 16'($urandom_range(2000, 16))
                                       : 16'($urandom_range(65535, 16));
               configure(lo, hi, cap);
            end
         endcase
         if ($urandom_range(3) == 0) csr_write(CSR_SPARE, 16'($urandom()));
         case (phase % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 48; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 48; end
            default: begin sender_idle_pct = 13; stall_pct = 13; end
         endcase
         if ($urandom_range(1)) now_ms = $urandom();
         run_frames(PHASE_FRAMES);
         settle();
      end

      repeat (END_WAIT) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("video_qp_rate_controller: match");
      else
         $display("video_qp_rate_controller: mismatch");
      $finish;
   end
endmodule
